// ===== hw/rtl/wtosc_pkg.sv =====
package wtosc_pkg;

  // Field widths of the ports.
  localparam int FREQ_W   = 24;
  localparam int SR_W     = 18;
  localparam int TL_W     = 11;
  localparam int IDX_W    = 10;
  localparam int VAL_W    = 16;
  localparam int SAMPLE_W = 16;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = SR_W;

  // Defaults of the top-level parameters.
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF  = 32;

  // Blend weight table: (1 - cos(pi*mu)) / 2 in unsigned Q0.16, up to 65536.
  localparam int COS_DEPTH = 256;
  localparam int COS_W     = $clog2(COS_DEPTH);
  localparam int W_W       = 17;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the configuration registers.
  localparam logic [SR_W-1:0] SR_RESET = SR_W'(44100);
  localparam logic [TL_W-1:0] TL_RESET = TL_W'(2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 1'b1;

  // Operation codes of an input beat.
  localparam logic [OP_W-1:0] OP_SET_FREQ = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE    = 2'd2;

  // Wavetable values loaded by the clearing pass.
  localparam logic [VAL_W-1:0] VAL_MIN = 16'h8000;
  localparam logic [VAL_W-1:0] VAL_MAX = 16'h7FFF;

  // Classified command handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_STEP,
    CMD_TICK,
    CMD_WRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               load_step;
    logic [FREQ_W-1:0]  frequency;
    logic [IDX_W-1:0]   index;
    logic [VAL_W-1:0]   value;
  } cmd_t;

  typedef logic [W_W-1:0] blend_tab_t [COS_DEPTH];

  // Builds the weight table: s = sin(pi*k/(2*D)) in Q30 by a truncated
  // Taylor series, weight = s*s >> 44, clamped to one.
  function automatic blend_tab_t blend_table();
    blend_tab_t tab;
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] s;
    for (int k = 0; k < COS_DEPTH; k++) begin
      theta = (PI_Q30 * 64'(k)) / 64'(2 * COS_DEPTH);
      term = theta;
      s = theta;
      for (int n = 1; n <= 8; n++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) begin
          s = (s >= term) ? s - term : 64'd0;
        end else begin
          s = s + term;
        end
      end
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      s = (s * s) >> 44;
      if (s > 64'd65536) s = 64'd65536;
      tab[k] = W_W'(s);
    end
    return tab;
  endfunction

endpackage

// ===== hw/rtl/wtosc_front.sv =====
module wtosc_front #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [wtosc_pkg::OP_W-1:0]        op,
  input  logic [wtosc_pkg::FREQ_W-1:0]      frequency,
  input  logic                              signal_connected,
  input  logic [wtosc_pkg::IDX_W-1:0]       table_index,
  input  logic signed [wtosc_pkg::VAL_W-1:0] table_value,
  input  logic                              init_done,
  output logic                              push_valid,
  input  logic                              push_ready,
  output wtosc_pkg::cmd_t                   push_cmd
);
  import wtosc_pkg::*;

  logic hold_valid;
  cmd_t hold_cmd;
  cmd_t cmd;
  logic keep;

  // Classify the incoming beat; unknown codes and writes past the table drop.
  always_comb begin
    cmd.kind      = CMD_TICK;
    cmd.load_step = signal_connected;
    cmd.frequency = frequency;
    cmd.index     = table_index;
    cmd.value     = table_value;
    keep          = 1'b0;
    case (op)
      OP_SET_FREQ: begin
        cmd.kind      = CMD_STEP;
        cmd.load_step = 1'b1;
        keep          = 1'b1;
      end
      OP_TICK: begin
        cmd.kind = CMD_TICK;
        keep     = 1'b1;
      end
      OP_WRITE: begin
        cmd.kind = CMD_WRITE;
        keep     = 32'(table_index) < 32'(TABLE_DEPTH);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready   = init_done && (!hold_valid || push_ready);
  assign push_valid = hold_valid;
  assign push_cmd   = hold_cmd;

  // One holding register in front of the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      hold_valid <= keep;
      hold_cmd   <= cmd;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/wtosc_queue.sv =====
module wtosc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  wtosc_pkg::cmd_t push_cmd,
  output logic            head_valid,
  output wtosc_pkg::cmd_t head_cmd,
  input  logic            pop
);
  import wtosc_pkg::*;

  localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = slots[rd_ptr];
  assign push       = push_valid && push_ready;

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QA_W'(1);
      end
      if (push && !pop) count <= count + CNT_W'(1);
      else if (!push && pop) count <= count - CNT_W'(1);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + CNT_W'(1))
    else $error("queue count missed a beat");

endmodule

// ===== hw/rtl/wtosc_div.sv =====
module wtosc_div #(
  parameter int PHASE_BITS = wtosc_pkg::PHASE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wtosc_pkg::FREQ_W-1:0] frequency,
  input  logic [wtosc_pkg::SR_W-1:0]   sample_rate,
  output logic                         done,
  output logic [PHASE_BITS-1:0]        quotient
);
  import wtosc_pkg::*;

  // Divides frequency * 2^PHASE_BITS by sample_rate * 256, one bit a cycle;
  // only the fractional part of the quotient is kept.
  localparam int D_W   = SR_W + 8;
  localparam int STEPS = FREQ_W + PHASE_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [CNT_W-1:0]  cnt;
  logic [D_W-1:0]    divisor;
  logic [D_W-1:0]    rem;
  logic [FREQ_W-1:0] num;
  logic [D_W:0]      trial;
  logic              fits;
  logic [D_W-1:0]    rem_next;
  logic              busy;

  assign busy  = cnt != '0;
  assign trial = {rem, num[FREQ_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    if (fits) rem_next = D_W'(trial - {1'b0, divisor});
    else rem_next = D_W'(trial);
  end

  // Restoring shift-subtract loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (cnt == CNT_W'(1));
      if (start) begin
        divisor <= {((sample_rate == '0) ? SR_W'(1) : sample_rate), 8'd0};
        rem     <= '0;
        num     <= frequency;
        cnt     <= CNT_W'(STEPS);
      end else if (busy) begin
        rem      <= rem_next;
        num      <= num << 1;
        quotient <= {quotient[PHASE_BITS-2:0], fits};
        cnt      <= cnt - CNT_W'(1);
      end
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== hw/rtl/wtosc_back.sv =====
module wtosc_back #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = wtosc_pkg::PHASE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               head_valid,
  input  wtosc_pkg::cmd_t                    head_cmd,
  output logic                               pop,
  input  logic [wtosc_pkg::SR_W-1:0]         sample_rate,
  input  logic [wtosc_pkg::TL_W-1:0]         table_length,
  output logic                               init_done,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0] sample_out
);
  import wtosc_pkg::*;

  localparam int TD_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int LEN_W  = TD_W + 1;
  localparam int P_W    = PHASE_BITS + LEN_W;
  localparam int PROD_W = VAL_W + W_W + 2;
  localparam int RES_W  = VAL_W + 4;
  localparam blend_tab_t BLEND_W = blend_table();

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ADV,
    S_MUL,
    S_RD,
    S_PROD,
    S_OUT
  } state_t;

  state_t                   state;
  logic [TD_W-1:0]          clr_addr;
  logic                     is_tick;
  logic [PHASE_BITS-1:0]    phase;
  logic [PHASE_BITS-1:0]    phase_step;
  logic [P_W-1:0]           p;
  logic signed [VAL_W-1:0]  rd_a;
  logic signed [VAL_W-1:0]  rd_b;
  logic [W_W-1:0]           w_q;
  logic signed [PROD_W-1:0] prod;

  logic [VAL_W-1:0]         wave_mem [TABLE_DEPTH];
  logic                     mem_we;
  logic [TD_W-1:0]          mem_waddr;
  logic [VAL_W-1:0]         mem_wdata;

  logic                     div_start;
  logic                     div_done;
  logic [PHASE_BITS-1:0]    div_q;

  logic [LEN_W-1:0]         len_eff;
  logic [TD_W-1:0]          i0;
  logic [LEN_W-1:0]         i1_raw;
  logic [TD_W-1:0]          i1;
  logic [COS_W-1:0]         k;

  logic signed [VAL_W:0]    diff;
  logic signed [W_W:0]      w_s;
  logic signed [PROD_W-1:0] rnd;
  logic signed [RES_W-1:0]  sum_w;
  logic [VAL_W-1:0]         sat;

  assign init_done = state != S_CLEAR;
  assign pop       = (state == S_IDLE) && head_valid;
  assign div_start = pop && ((head_cmd.kind == CMD_STEP) ||
                             ((head_cmd.kind == CMD_TICK) && head_cmd.load_step));

  wtosc_div #(
    .PHASE_BITS(PHASE_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .frequency  (head_cmd.frequency),
    .sample_rate(sample_rate),
    .done       (div_done),
    .quotient   (div_q)
  );

  // Table length in use: zero counts as one, large values saturate.
  always_comb begin
    if (table_length == '0) len_eff = LEN_W'(1);
    else if (32'(table_length) > 32'(TABLE_DEPTH)) len_eff = LEN_W'(TABLE_DEPTH);
    else len_eff = LEN_W'(table_length);
  end

  // Neighbor entries and blend index from the scaled phase.
  always_comb begin
    i0     = p[PHASE_BITS +: TD_W];
    i1_raw = LEN_W'(i0) + LEN_W'(1);
    i1     = (i1_raw >= len_eff) ? '0 : i1_raw[TD_W-1:0];
    k      = p[PHASE_BITS-1 -: COS_W];
  end

  // Table write port: the clearing pass after reset, then op 2 writes.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      if (clr_addr == TD_W'(0)) mem_wdata = VAL_MIN;
      else if (clr_addr == TD_W'(1)) mem_wdata = VAL_MAX;
    end else if (pop && (head_cmd.kind == CMD_WRITE)) begin
      mem_we    = 1'b1;
      mem_waddr = TD_W'(head_cmd.index);
      mem_wdata = head_cmd.value;
    end
  end

  // Wavetable memory with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) wave_mem[mem_waddr] <= mem_wdata;
    if (state == S_RD) begin
      rd_a <= $signed(wave_mem[i0]);
      rd_b <= $signed(wave_mem[i1]);
    end
  end

  // Blend arithmetic: rounded (b - a) * w / 65536 added to a, then clamped.
  always_comb begin
    diff  = $signed({rd_b[VAL_W-1], rd_b}) - $signed({rd_a[VAL_W-1], rd_a});
    w_s   = $signed({1'b0, w_q});
    rnd   = (prod + PROD_W'(32768)) >>> 16;
    sum_w = $signed(rnd[RES_W-1:0]) + RES_W'(rd_a);
    if (sum_w[RES_W-1:VAL_W-1] == '0 || sum_w[RES_W-1:VAL_W-1] == '1) begin
      sat = sum_w[VAL_W-1:0];
    end else if (sum_w[RES_W-1]) begin
      sat = VAL_MIN;
    end else begin
      sat = VAL_MAX;
    end
  end

  // Sequencer for commands taken from the queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      phase      <= '0;
      phase_step <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + TD_W'(1);
          if (clr_addr == TD_W'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            is_tick <= head_cmd.kind == CMD_TICK;
            if (div_start) state <= S_DIV;
            else if (head_cmd.kind == CMD_TICK) state <= S_ADV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            phase_step <= div_q;
            state      <= is_tick ? S_ADV : S_IDLE;
          end
        end
        S_ADV: begin
          phase <= phase + phase_step;
          state <= S_MUL;
        end
        S_MUL: begin
          p     <= P_W'(phase) * P_W'(len_eff);
          state <= S_RD;
        end
        S_RD: begin
          w_q   <= BLEND_W[k];
          state <= S_PROD;
        end
        S_PROD: begin
          prod  <= diff * w_s;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            sample_out <= $signed(sat);
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_out_from_render: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("sample loaded outside the output step");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished while not awaited");

endmodule

// ===== hw/rtl/wavetable_oscillator_cosine_interp.sv =====
// Channel   Handshake            Beat contents
// in        in_valid/in_ready    op, frequency, signal_connected, table_index, table_value
// out       out_valid/out_ready  sample_out
// cfg       cfg_write            cfg_index, cfg_data (no wait, no read-back)
//
// After reset a clearing pass loads all TABLE_DEPTH wavetable entries (1024 by
// default); in_ready stays low until it ends, config writes are taken throughout.
// A table write is done in the back end as it is popped; a tick from the stored step
// runs through S_ADV, S_MUL, S_RD, S_PROD and S_OUT. A frequency set waits in S_DIV
// on the bit-serial step divider; a tick that loads a new frequency waits there too,
// then runs the same tick states.
// A two-entry command queue lets the input run ahead while out_ready is low.
module wavetable_oscillator_cosine_interp #(
  parameter int TABLE_DEPTH = wtosc_pkg::TABLE_DEPTH_DEF,
  parameter int PHASE_BITS  = wtosc_pkg::PHASE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [wtosc_pkg::OP_W-1:0]            op,
  input  logic [wtosc_pkg::FREQ_W-1:0]          frequency,
  input  logic                                  signal_connected,
  input  logic [wtosc_pkg::IDX_W-1:0]           table_index,
  input  logic signed [wtosc_pkg::VAL_W-1:0]    table_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wtosc_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                  cfg_write,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wtosc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wtosc_pkg::*;

  logic [SR_W-1:0] sample_rate;
  logic [TL_W-1:0] table_length;
  logic            init_done;
  logic            push_valid;
  logic            push_ready;
  cmd_t            push_cmd;
  logic            head_valid;
  cmd_t            head_cmd;
  logic            pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= SR_RESET;
      table_length <= TL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_RATE:  sample_rate  <= cfg_data[SR_W-1:0];
        CFG_TABLE_LENGTH: table_length <= cfg_data[TL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accepts and classifies input beats.
  wtosc_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .frequency       (frequency),
    .signal_connected(signal_connected),
    .table_index     (table_index),
    .table_value     (table_value),
    .init_done       (init_done),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_cmd        (push_cmd)
  );

  // Command queue between the two halves.
  wtosc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop)
  );

  // Back end: step divider, phase, table and blend.
  wtosc_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .sample_rate (sample_rate),
    .table_length(table_length),
    .init_done   (init_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out)
  );

endmodule

// ===== bench/tb_wavetable_oscillator_cosine_interp.sv =====
`timescale 1ns / 100ps

module tb_wavetable_oscillator_cosine_interp;
  import wtosc_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int PB              = PHASE_BITS_DEF;
  localparam int QUIET_LIMIT     = 6000;
  localparam int SETTLE_CYCLES   = 300;
  localparam int PHASE_COUNT     = 8;
  localparam int BEATS_PER_PHASE = 235;
  // Frequency word equal to the reset sample rate, in Q16.8.
  localparam logic [FREQ_W-1:0] FULL_SCALE = FREQ_W'(44100 * 256);

  // Shadow copy of the oscillator: registers, phase, step, wavetable and the
  // samples that the block still owes.
  class osc_shadow;
    bit [SR_W-1:0] rate;
    bit [TL_W-1:0] length;
    bit [PB-1:0] phase;
    bit [PB-1:0] step;
    bit signed [VAL_W-1:0] wave [TABLE_DEPTH_DEF];
    bit [W_W-1:0] weight [COS_DEPTH];
    logic signed [SAMPLE_W-1:0] owed_samples [$];
    int errors;
    int ticks;
    int writes;
    int steps;

    function new();
      rate = SR_RESET;
      length = TL_RESET;
      phase = '0;
      step = '0;
      foreach (wave[i]) wave[i] = '0;
      wave[0] = VAL_MIN;
      wave[1] = VAL_MAX;
      foreach (weight[k]) weight[k] = sine_sq(k);
      errors = 0;
      ticks = 0;
      writes = 0;
      steps = 0;
    endfunction

    // Blend weight for slot k: the square of sin(pi*k/(2*D)) in Q30, taken
    // from a Taylor series with every product truncated, then scaled to Q0.16.
    function bit [W_W-1:0] sine_sq(int unsigned k);
      longint unsigned theta;
      longint unsigned term;
      longint unsigned s;
      theta = (PI_Q30 * k) / (2 * COS_DEPTH);
      term = theta;
      s = theta;
      for (int n = 1; n <= 8; n++) begin
        term = (term * theta) >> 30;
        term = (term * theta) >> 30;
        term = term / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          s = (s >= term) ? s - term : 0;
        end else begin
          s = s + term;
        end
      end
      if (s > (64'd1 << 30)) s = 64'd1 << 30;
      s = (s * s) >> 44;
      if (s > 65536) s = 65536;
      return s[W_W-1:0];
    endfunction

    // Phase step as the fraction frequency / (rate * 256), by long division.
    // The whole-cycle part is dropped first since the phase wraps anyway.
    function bit [PB-1:0] step_of(bit [FREQ_W-1:0] f);
      longint unsigned d;
      longint unsigned r;
      longint unsigned q;
      d = 64'(rate) * 256;
      if (d == 0) d = 256;
      r = f % d;
      q = 0;
      repeat (PB) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q = q | 1;
        end
      end
      return q[PB-1:0];
    endfunction

    // Interpolated sample at the current phase.
    function logic signed [SAMPLE_W-1:0] blend();
      longint unsigned len;
      longint unsigned p;
      longint unsigned i0;
      longint unsigned i1;
      longint unsigned frac;
      longint unsigned k;
      longint a;
      longint b;
      longint acc;
      len = length;
      if (len == 0) len = 1;
      if (len > TABLE_DEPTH_DEF) len = TABLE_DEPTH_DEF;
      p = 64'(phase) * len;
      i0 = p >> PB;
      frac = p & ((64'd1 << PB) - 1);
      if (i0 >= len) i0 = len - 1;
      i1 = i0 + 1;
      if (i1 >= len) i1 = 0;
      k = (frac * COS_DEPTH) >> PB;
      if (k >= COS_DEPTH) k = COS_DEPTH - 1;
      a = wave[i0];
      b = wave[i1];
      // Rounded to nearest, ties toward plus infinity.
      acc = (b - a) * longint'(weight[k]) + 64'sd32768;
      acc = a + (acc >>> 16);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      return acc[SAMPLE_W-1:0];
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      if (idx == CFG_SAMPLE_RATE) begin
        rate = data[SR_W-1:0];
      end else begin
        length = data[TL_W-1:0];
      end
    endfunction

    // Applies one accepted input beat and queues the sample it causes.
    function void take_command(bit [OP_W-1:0] code, bit [FREQ_W-1:0] f, bit conn,
                               bit [IDX_W-1:0] slot, bit [VAL_W-1:0] level);
      case (code)
        OP_SET_FREQ: begin
          step = step_of(f);
          steps++;
        end
        OP_TICK: begin
          if (conn) step = step_of(f);
          phase = phase + step;
          owed_samples.push_back(blend());
          ticks++;
        end
        OP_WRITE: begin
          wave[slot] = level;
          writes++;
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted output beat with the oldest owed sample.
    function void match_sample(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (owed_samples.size() == 0) begin
        $display("%0t: sample_out %0d arrived with no sample owed", $time, got);
        errors++;
      end else begin
        want = owed_samples.pop_front();
        if (got !== want) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [OP_W-1:0] op;
  logic [FREQ_W-1:0] frequency;
  logic signal_connected;
  logic [IDX_W-1:0] table_index;
  logic signed [VAL_W-1:0] table_value;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle = 18;
  int recv_idle = 80;
  int quiet_cycles = 0;
  int beats_in = 0;
  osc_shadow shadow;

  wavetable_oscillator_cosine_interp i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output side: ready is redrawn on every falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.match_sample(sample_out);
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
      $display("tb_wavetable_oscillator_cosine_interp NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one input beat, starting and ending at a falling edge.
  task automatic send_beat(input logic [OP_W-1:0] code, input logic [FREQ_W-1:0] f,
                           input logic conn, input logic [IDX_W-1:0] slot,
                           input logic [VAL_W-1:0] level);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    op = code;
    frequency = f;
    signal_connected = conn;
    table_index = slot;
    table_value = level;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.take_command(code, f, conn, slot, level);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(data);
    @(negedge clk);
    cfg_write = 1'b0;
    shadow.set_reg(idx, CFG_DATA_W'(data));
  endtask

  // Waits for every owed sample, then lets in-flight step loads finish.
  task automatic drain();
    in_valid = 1'b0;
    while (shadow.owed_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Frequencies: zero, full scale, below the sample rate, small steps, any.
  function automatic logic [FREQ_W-1:0] pick_freq();
    longint unsigned d;
    int unsigned sel;
    d = 64'(shadow.rate) * 256;
    if (d == 0) d = 256;
    if (d > 64'hFFFFFF) d = 64'h1000000;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 12) return '1;
    if (sel < 50) return FREQ_W'($urandom_range(int'(d - 1)));
    if (sel < 70) return FREQ_W'($urandom_range(int'(d / 16)));
    return FREQ_W'($urandom);
  endfunction

  // Edges of the fields and the odd cases, under the reset registers.
  task automatic run_directed();
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_SET_FREQ, FULL_SCALE / 2, 1'b0, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_SET_FREQ, '1, 1'b0, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '1, '1);
    send_beat(OP_TICK, FULL_SCALE / 4, 1'b1, '0, '0);
    send_beat(OP_TICK, FULL_SCALE, 1'b1, '0, '0);
    send_beat(OP_TICK, '0, 1'b1, '0, '0);
    // An unknown opcode must leave everything alone.
    send_beat(OP_UNKNOWN, '1, 1'b1, '0, '0);
    send_beat(OP_WRITE, '0, 1'b0, 10'd0, VAL_MAX);
    send_beat(OP_WRITE, '0, 1'b0, 10'd1, VAL_MIN);
    send_beat(OP_WRITE, '1, 1'b1, '1, VAL_MAX);
    send_beat(OP_WRITE, '0, 1'b0, 10'd512, 16'h5555);
    send_beat(OP_TICK, FULL_SCALE / 3, 1'b1, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_SET_FREQ, 24'd1, 1'b1, '0, '0);
    send_beat(OP_TICK, '0, 1'b0, '0, '0);
    send_beat(OP_WRITE, '0, 1'b0, 10'd0, 16'h0000);
    send_beat(OP_TICK, FULL_SCALE - 1, 1'b1, '0, '0);
    send_beat(OP_TICK, '1, 1'b1, '0, '0);
  endtask

  // Random beats; entries are mostly written inside the active length.
  task automatic run_random(input int count);
    int done;
    int unsigned sel;
    int unsigned len_eff;
    logic [OP_W-1:0] code;
    logic [IDX_W-1:0] slot;
    logic [VAL_W-1:0] level;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(99);
      if (sel < 12) code = OP_SET_FREQ;
      else if (sel < 67) code = OP_TICK;
      else if (sel < 95) code = OP_WRITE;
      else code = OP_UNKNOWN;
      len_eff = shadow.length;
      if (len_eff == 0) len_eff = 1;
      if (len_eff > TABLE_DEPTH_DEF) len_eff = TABLE_DEPTH_DEF;
      if ($urandom_range(99) < 70) slot = IDX_W'($urandom_range(len_eff - 1));
      else slot = IDX_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 5) level = VAL_MIN;
      else if (sel < 10) level = VAL_MAX;
      else level = VAL_W'($urandom);
      send_beat(code, pick_freq(), 1'($urandom), slot, level);
      if (code != OP_UNKNOWN) done++;
    end
  endtask

  initial begin
    int unsigned rate_plan [PHASE_COUNT];
    int unsigned len_plan [PHASE_COUNT];
    shadow = new();
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_SET_FREQ;
    frequency = '0;
    signal_connected = 1'b0;
    table_index = '0;
    table_value = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_SAMPLE_RATE;
    cfg_data = '0;
    // Register settings: zero, one, the top of the range and the all-ones field.
    rate_plan = '{48000, 1, 192000, 0, 262143, 0, 44100, 8000};
    len_plan = '{1024, 1, 0, 2047, 16, 0, 1025, 0};
    rate_plan[5] = $urandom_range(192000, 1);
    len_plan[5] = $urandom_range(1024, 1);
    len_plan[7] = $urandom_range(200, 3);
    repeat (10) @(negedge clk);
    rst = 1'b0;

    run_directed();
    drain();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      // Sender mostly idle in the middle third, no idling in the last.
      if (p == 3) begin
        send_idle = 80;
        recv_idle = 18;
      end
      if (p == 6) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(CFG_SAMPLE_RATE, rate_plan[p]);
      write_reg(CFG_TABLE_LENGTH, len_plan[p]);
      run_random(BEATS_PER_PHASE);
      drain();
    end

    $display("Sent %0d beats: %0d samples checked, %0d step loads, %0d table writes,",
             beats_in, shadow.ticks, shadow.steps, shadow.writes);
    $display("across %0d register settings with zero, saturating and full-scale values.",
             PHASE_COUNT + 1);
    if (shadow.errors == 0) begin
      $display("tb_wavetable_oscillator_cosine_interp OK");
    end else begin
      $display("tb_wavetable_oscillator_cosine_interp NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/wtosc_pkg.sv
hw/rtl/wtosc_front.sv
hw/rtl/wtosc_queue.sv
hw/rtl/wtosc_div.sv
hw/rtl/wtosc_back.sv
hw/rtl/wavetable_oscillator_cosine_interp.sv
bench/tb_wavetable_oscillator_cosine_interp.sv
